// ----- hdl/hbm_pkg.sv -----
// Shared types, constants and vertex tables for the heightmap block mesher.
package hbm_pkg;

    // Default grid limits
    localparam int unsigned MAX_WIDTH_DEF = 1024;
    localparam int unsigned MAX_ROWS_DEF  = 1024;

    // Field widths
    localparam int unsigned HEIGHT_W = 8;
    localparam int unsigned VOXEL_W  = 16;
    localparam int unsigned RWIDTH_W = 11;
    localparam int unsigned X_W      = 26;
    localparam int unsigned Y_W      = 24;
    localparam int unsigned Z_W      = 26;
    localparam int unsigned SHADE_W  = 8;

    // Cell index width covering the largest grid (4096), and one more for the +1 corner
    localparam int unsigned IDX_W = 12;
    localparam int unsigned XS_W  = IDX_W + 1;
    localparam int unsigned PROD_W = XS_W + VOXEL_W;

    // Width used for row length compares, large enough for the largest grid
    localparam int unsigned CMP_W = 13;

    // Output stream payload
    localparam int unsigned M_DATA_W = ((X_W + Y_W + Z_W + SHADE_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam int unsigned CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_VOXEL_SIZE = 1'd1;

    // Reset values of the configuration registers
    localparam logic [RWIDTH_W-1:0] ROW_WIDTH_RST  = 11'd1024;
    localparam logic [VOXEL_W-1:0]  VOXEL_SIZE_RST = 16'd256;

    // Request queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // Faces of one cell, in emission order
    typedef enum logic [1:0] {
        FACE_TOP,
        FACE_LEFT,
        FACE_FRONT
    } face_t;

    localparam logic [2:0] LAST_VTX = 3'd5;

    // Per vertex: x offset, z offset, use the other height
    typedef struct packed {
        logic dx;
        logic dz;
        logic other;
    } vtx_attr_t;

    localparam logic [2:0] TOP_LUT [6] = '{3'b000, 3'b100, 3'b110, 3'b000, 3'b010, 3'b110};
    localparam logic [2:0] LEFT_LUT [6] = '{3'b000, 3'b001, 3'b011, 3'b000, 3'b011, 3'b010};
    localparam logic [2:0] FRONT_LUT [6] = '{3'b000, 3'b001, 3'b101, 3'b000, 3'b100, 3'b101};

    // Look up the corner of vertex v of face f
    function automatic vtx_attr_t vtx_attr(face_t f, logic [2:0] v);
        logic [2:0] bits;
        bits = 3'b000;
        if (v <= LAST_VTX)
        begin
            unique case (f)
                FACE_TOP:   bits = TOP_LUT[v];
                FACE_LEFT:  bits = LEFT_LUT[v];
                FACE_FRONT: bits = FRONT_LUT[v];
                default:    bits = 3'b000;
            endcase
        end
        return vtx_attr_t'(bits);
    endfunction

    // One classified sample, handed from front to back
    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [HEIGHT_W-1:0] left_code;
        logic [HEIGHT_W-1:0] front_code;
        logic [IDX_W-1:0]    col;
        logic [IDX_W-1:0]    row;
        logic                has_left;
        logic                has_front;
    } cell_req_t;

endpackage

// ----- hdl/hbm_front.sv -----
// Front end: sample intake, counters, previous-row line buffer and cell classification.
module hbm_front
    import hbm_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int unsigned MAX_ROWS  = MAX_ROWS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [HEIGHT_W-1:0] height,
    input  logic                first_of_map,
    input  logic [RWIDTH_W-1:0] row_width,
    output logic                req_valid,
    input  logic                req_ready,
    output cell_req_t           req
);

    localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned ROW_W = $clog2(MAX_ROWS + 1);

    logic [HEIGHT_W-1:0] mem [MAX_WIDTH];

    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [HEIGHT_W-1:0] left_reg;
    logic                s2_vld_reg, s2_vld_next;
    logic [HEIGHT_W-1:0] s2_h_reg;
    logic [HEIGHT_W-1:0] s2_left_reg;
    logic [IDX_W-1:0]    s2_col_reg;
    logic [IDX_W-1:0]    s2_row_reg;
    logic                s2_has_left_reg;
    logic                s2_has_front_reg;
    logic                s2_row_zero_reg;
    logic [HEIGHT_W-1:0] above_reg;

    logic                accept;
    logic                live;
    logic [COL_W-1:0]    col_c;
    logic [ROW_W-1:0]    row_c;
    logic [CMP_W-1:0]    rw_cmp;
    logic [CMP_W-1:0]    width_eff;
    logic                row_end;

    // Stage two drains into the queue, so take a sample whenever it is free or moving
    assign in_ready = !s2_vld_reg || req_ready;
    assign accept   = in_valid && in_ready;

    // Restart the counters on the start-of-map mark
    assign col_c = first_of_map ? '0 : col_reg;
    assign row_c = first_of_map ? '0 : row_reg;
    assign live  = (row_c < ROW_W'(MAX_ROWS));

    // Clamp the row length to the buffer size, and treat zero as one
    always_comb
    begin
        rw_cmp = CMP_W'(row_width);
        if (rw_cmp == '0)
            width_eff = CMP_W'(1);
        else if (rw_cmp > CMP_W'(MAX_WIDTH))
            width_eff = CMP_W'(MAX_WIDTH);
        else
            width_eff = rw_cmp;
        row_end = (CMP_W'(col_c) + CMP_W'(1)) >= width_eff;
    end

    // Advance the column and row counters
    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        s2_vld_next = s2_vld_reg;
        if (s2_vld_reg && req_ready)
            s2_vld_next = 1'b0;
        if (accept)
        begin
            col_next = col_c;
            row_next = row_c;
            if (live)
            begin
                s2_vld_next = 1'b1;
                if (row_end)
                begin
                    col_next = '0;
                    row_next = row_c + ROW_W'(1);
                end
                else
                begin
                    col_next = col_c + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            s2_vld_reg <= s2_vld_next;
            if (accept && live)
                left_reg <= height;
        end
    end

    // Capture the classified sample
    always_ff @(posedge clk)
    begin
        if (accept && live)
        begin
            s2_h_reg         <= height;
            s2_left_reg      <= (col_c != '0) ? left_reg : '0;
            s2_col_reg       <= IDX_W'(col_c);
            s2_row_reg       <= IDX_W'(row_c);
            s2_has_left_reg  <= (col_c != '0) || (height != '0);
            s2_has_front_reg <= (row_c != '0) || (height != '0);
            s2_row_zero_reg  <= (row_c == '0);
        end
    end

    // Line buffer: read the old height above, then store this one
    always_ff @(posedge clk)
    begin
        if (accept && live)
        begin
            above_reg  <= mem[col_c];
            mem[col_c] <= height;
        end
    end

    assign req_valid       = s2_vld_reg;
    assign req.height      = s2_h_reg;
    assign req.left_code   = s2_left_reg;
    assign req.front_code  = s2_row_zero_reg ? '0 : above_reg;
    assign req.col         = s2_col_reg;
    assign req.row         = s2_row_reg;
    assign req.has_left    = s2_has_left_reg;
    assign req.has_front   = s2_has_front_reg;

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= ROW_W'(MAX_ROWS))
        else $error("row counter passed its limit");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(col_reg) < CMP_W'(MAX_WIDTH))
        else $error("column counter outside the line buffer");

endmodule

// ----- hdl/hbm_queue.sv -----
// Short request queue between the classifying front end and the vertex emitter.
module hbm_queue
    import hbm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  cell_req_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output cell_req_t pop_data
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    cell_req_t        slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot[rd_ptr_reg];

    // Advance the pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (push)
            slot[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count overran its depth");

endmodule

// ----- hdl/hbm_back.sv -----
// Back end: steps through the faces of one cell and emits scaled vertices.
module hbm_back
    import hbm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  cell_req_t           req,
    input  logic [VOXEL_W-1:0]  voxel_size,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [X_W-1:0]      vert_x,
    output logic [Y_W-1:0]      vert_y,
    output logic [Z_W-1:0]      vert_z,
    output logic [SHADE_W-1:0]  shade,
    output logic                last_of_cell
);

    // Sequencer state
    cell_req_t           cur_reg;
    logic                cur_vld_reg;
    face_t               face_reg;
    logic [2:0]          vtx_reg;

    // Vertex select stage
    logic                a_vld_reg;
    logic [XS_W-1:0]     a_xs_reg;
    logic [XS_W-1:0]     a_zs_reg;
    logic [HEIGHT_W-1:0] a_code_reg;
    logic                a_last_reg;

    // Output register
    logic                o_vld_reg;
    logic [X_W-1:0]      o_x_reg;
    logic [Y_W-1:0]      o_y_reg;
    logic [Z_W-1:0]      o_z_reg;
    logic [SHADE_W-1:0]  o_shade_reg;
    logic                o_last_reg;

    logic                o_adv, a_adv, issue, is_last, fin, pop;
    vtx_attr_t           attr;
    logic [HEIGHT_W-1:0] other_code;
    logic [HEIGHT_W-1:0] code;
    face_t               face_after;
    logic [PROD_W-1:0]   prod_x, prod_z;
    logic [Y_W-1:0]      prod_y;

    assign o_adv = !o_vld_reg || out_ready;
    assign a_adv = !a_vld_reg || o_adv;
    assign issue = cur_vld_reg && a_adv;

    // Pick the corner and height of the current vertex
    always_comb
    begin
        attr = vtx_attr(face_reg, vtx_reg);
        unique case (face_reg)
            FACE_TOP:   other_code = cur_reg.height;
            FACE_LEFT:  other_code = cur_reg.left_code;
            FACE_FRONT: other_code = cur_reg.front_code;
            default:    other_code = cur_reg.height;
        endcase
        code = attr.other ? other_code : cur_reg.height;
    end

    // Work out the face that follows and whether this vertex closes the cell
    always_comb
    begin
        face_after = cur_reg.has_left ? FACE_LEFT : FACE_FRONT;
        is_last    = 1'b0;
        unique case (face_reg)
            FACE_TOP:
            begin
                face_after = cur_reg.has_left ? FACE_LEFT : FACE_FRONT;
                is_last    = !cur_reg.has_left && !cur_reg.has_front;
            end
            FACE_LEFT:
            begin
                face_after = FACE_FRONT;
                is_last    = !cur_reg.has_front;
            end
            FACE_FRONT:
            begin
                face_after = FACE_FRONT;
                is_last    = 1'b1;
            end
            default:
            begin
                face_after = FACE_FRONT;
                is_last    = 1'b1;
            end
        endcase
        is_last = is_last && (vtx_reg == LAST_VTX);
    end

    assign fin       = issue && is_last;
    assign req_ready = !cur_vld_reg || fin;
    assign pop       = req_valid && req_ready;

    // Step through vertices and faces, load the next request on completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_vld_reg <= 1'b0;
            face_reg    <= FACE_TOP;
            vtx_reg     <= '0;
        end
        else if (pop)
        begin
            cur_vld_reg <= 1'b1;
            face_reg    <= FACE_TOP;
            vtx_reg     <= '0;
        end
        else if (fin)
        begin
            cur_vld_reg <= 1'b0;
        end
        else if (issue)
        begin
            if (vtx_reg == LAST_VTX)
            begin
                vtx_reg  <= '0;
                face_reg <= face_after;
            end
            else
            begin
                vtx_reg <= vtx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= req;
    end

    // Vertex select stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (a_adv)
            a_vld_reg <= issue;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            a_xs_reg   <= XS_W'(cur_reg.col) + XS_W'(attr.dx);
            a_zs_reg   <= XS_W'(cur_reg.row) + XS_W'(attr.dz);
            a_code_reg <= code;
            a_last_reg <= is_last;
        end
    end

    // Scale by the voxel size
    assign prod_x = PROD_W'(a_xs_reg) * PROD_W'(voxel_size);
    assign prod_z = PROD_W'(a_zs_reg) * PROD_W'(voxel_size);
    assign prod_y = Y_W'(a_code_reg) * Y_W'(voxel_size);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_vld_reg <= 1'b0;
        else if (o_adv)
            o_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (o_adv && a_vld_reg)
        begin
            o_x_reg     <= prod_x[X_W-1:0];
            o_y_reg     <= prod_y;
            o_z_reg     <= prod_z[Z_W-1:0];
            o_shade_reg <= a_code_reg;
            o_last_reg  <= a_last_reg;
        end
    end

    assign out_valid    = o_vld_reg;
    assign vert_x       = o_x_reg;
    assign vert_y       = o_y_reg;
    assign vert_z       = o_z_reg;
    assign shade        = o_shade_reg;
    assign last_of_cell = o_last_reg;

    a_left_face_used: assert property (@(posedge clk) disable iff (!rst_n)
        cur_vld_reg && (face_reg == FACE_LEFT) |-> cur_reg.has_left)
        else $error("left wall emitted for a cell without one");

    a_front_reached: assert property (@(posedge clk) disable iff (!rst_n)
        fin && (face_reg == FACE_TOP) |-> !cur_reg.has_left && !cur_reg.has_front)
        else $error("cell closed before its walls");

endmodule

// ----- hdl/heightmap_block_mesh_unit.sv -----
// Top level of the heightmap block mesher: configuration registers and stream wiring.
//
// Usage:
//   Height samples arrive in raster order on the s_ stream: s_tdata holds the
//   8-bit height, s_tuser marks the first sample of a map and restarts the
//   row and column counters. Each sample produces 6, 12 or 18 vertices on the
//   m_ stream (top face, left wall, front wall); m_tlast marks a sample's
//   final vertex. Rows at or beyond MAX_ROWS produce nothing.
//   A sample passes the line buffer read, queue, cell register, vertex
//   select and the multiply into the output register before its first
//   vertex. While m_tready is high the emitter puts out one vertex per
//   cycle, so a sample fills 6 to 18 output slots; the front end and a
//   two-entry queue keep taking samples while the emitter works.
//   Configuration (cfg_we, cfg_addr, cfg_wdata) is written while the block is
//   idle: index 0 is row_width, index 1 is voxel_size (unsigned Q8.8).
//   Reset clears the counters, the queue and all valid flags; row_width
//   returns to 1024 and voxel_size to 256. While m_tready is low the output
//   holds and the pipeline stalls back to s_tready.
module heightmap_block_mesh_unit
    import hbm_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int unsigned MAX_ROWS  = MAX_ROWS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [HEIGHT_W-1:0]   s_tdata,   // [7:0] height
    input  logic                  s_tuser,   // [0] first_of_map
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // vert_x, vert_y, vert_z, shade, zero fill
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [VOXEL_W-1:0]    cfg_wdata
);

    logic [RWIDTH_W-1:0] row_width_reg;
    logic [VOXEL_W-1:0]  voxel_size_reg;

    logic      f_valid, f_ready;
    cell_req_t f_req;
    logic      q_valid, q_ready;
    cell_req_t q_req;

    logic [X_W-1:0]     vert_x;
    logic [Y_W-1:0]     vert_y;
    logic [Z_W-1:0]     vert_z;
    logic [SHADE_W-1:0] shade;

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg  <= ROW_WIDTH_RST;
            voxel_size_reg <= VOXEL_SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ROW_WIDTH:  row_width_reg  <= cfg_wdata[RWIDTH_W-1:0];
                REG_VOXEL_SIZE: voxel_size_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    hbm_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .height       (s_tdata),
        .first_of_map (s_tuser),
        .row_width    (row_width_reg),
        .req_valid    (f_valid),
        .req_ready    (f_ready),
        .req          (f_req)
    );

    hbm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_req),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_req)
    );

    hbm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (q_valid),
        .req_ready    (q_ready),
        .req          (q_req),
        .voxel_size   (voxel_size_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .vert_x       (vert_x),
        .vert_y       (vert_y),
        .vert_z       (vert_z),
        .shade        (shade),
        .last_of_cell (m_tlast)
    );

    // Pack the vertex, first field lowest
    assign m_tdata = M_DATA_W'({shade, vert_z, vert_y, vert_x});

endmodule
